// ===== rtl/ipv4tv_pkg.sv =====
// Package for the IPv4 text validator: character codes, length limits and reject patterns.
`timescale 1ns / 1ps

package ipv4tv_pkg;

	localparam int MAX_LENGTH = 15;

	localparam int LEN_W   = 5;
	localparam int DOT_W   = 3;
	localparam int GRP_W   = 2;

	localparam logic [LEN_W-1:0] LEN_SAT = '1;
	localparam logic [DOT_W-1:0] DOT_SAT = '1;
	localparam logic [GRP_W-1:0] GRP_SAT = '1;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam int ZERO_LEN  = 7;
	localparam int BCAST_LEN = 15;

	localparam logic [7:0] ZERO_TEXT [ZERO_LEN] = '{
		8'h30, 8'h2E, 8'h30, 8'h2E, 8'h30, 8'h2E, 8'h30
	};

	localparam logic [7:0] BCAST_TEXT [BCAST_LEN] = '{
		8'h32, 8'h35, 8'h35, 8'h2E, 8'h32, 8'h35, 8'h35, 8'h2E,
		8'h32, 8'h35, 8'h35, 8'h2E, 8'h32, 8'h35, 8'h35
	};

	localparam logic [DOT_W-1:0] DOTS_NEEDED = 3'd3;

endpackage

// ===== rtl/ipv4tv_scan.sv =====
// Per-string scan state and verdict logic of the IPv4 text validator.
`timescale 1ns / 1ps

module ipv4tv_scan #(
	parameter int MAX_LENGTH = ipv4tv_pkg::MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] symbol,
	input  logic       final_req,
	output logic       verdict
);

	logic [ipv4tv_pkg::LEN_W-1:0] len_q, len_n;
	logic [ipv4tv_pkg::DOT_W-1:0] dots_q, dots_n;
	logic [ipv4tv_pkg::GRP_W-1:0] grp_q, grp_n;
	logic                         lead0_q, lead0_n;
	logic                         rej_q, rej_n;
	logic                         mzero_q, mzero_n;
	logic                         mbcast_q, mbcast_n;
	logic                         is_digit, is_dot;

	assign is_digit = (symbol >= ipv4tv_pkg::CHAR_ZERO) && (symbol <= ipv4tv_pkg::CHAR_NINE);
	assign is_dot   = (symbol == ipv4tv_pkg::CHAR_DOT);

	always_comb begin
		mzero_n  = mzero_q && (len_q < ipv4tv_pkg::LEN_W'(ipv4tv_pkg::ZERO_LEN))
			&& (ipv4tv_pkg::ZERO_TEXT[len_q[2:0]] == symbol);
		mbcast_n = mbcast_q && (len_q < ipv4tv_pkg::LEN_W'(ipv4tv_pkg::BCAST_LEN))
			&& (ipv4tv_pkg::BCAST_TEXT[len_q[3:0]] == symbol);

		rej_n   = rej_q;
		dots_n  = dots_q;
		grp_n   = grp_q;
		lead0_n = lead0_q;

		if ((len_q == '0) && !is_digit) begin
			rej_n = 1'b1;
		end

		len_n = (len_q == ipv4tv_pkg::LEN_SAT) ? len_q : len_q + 1'b1;
		if (len_n > ipv4tv_pkg::LEN_W'(MAX_LENGTH)) begin
			rej_n = 1'b1;
		end

		if (is_dot) begin
			if (grp_q == '0) begin
				rej_n = 1'b1;
			end
			if (dots_q != ipv4tv_pkg::DOT_SAT) begin
				dots_n = dots_q + 1'b1;
			end
			grp_n   = '0;
			lead0_n = 1'b0;
		end else if (is_digit) begin
			if (grp_q == '0) begin
				lead0_n = (symbol == ipv4tv_pkg::CHAR_ZERO);
				grp_n   = ipv4tv_pkg::GRP_W'(1);
			end else begin
				if (lead0_q) begin
					rej_n = 1'b1;
				end
				if (grp_q == ipv4tv_pkg::GRP_SAT) begin
					rej_n = 1'b1;
				end else begin
					grp_n = grp_q + 1'b1;
				end
			end
		end else begin
			rej_n = 1'b1;
		end

		verdict = !rej_n && (dots_n == ipv4tv_pkg::DOTS_NEEDED) && (grp_n != '0)
			&& !(mzero_n && (len_n == ipv4tv_pkg::LEN_W'(ipv4tv_pkg::ZERO_LEN)))
			&& !(mbcast_n && (len_n == ipv4tv_pkg::LEN_W'(ipv4tv_pkg::BCAST_LEN)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			dots_q   <= '0;
			grp_q    <= '0;
			lead0_q  <= 1'b0;
			rej_q    <= 1'b0;
			mzero_q  <= 1'b1;
			mbcast_q <= 1'b1;
		end else if (en) begin
			if (final_req) begin
				len_q    <= '0;
				dots_q   <= '0;
				grp_q    <= '0;
				lead0_q  <= 1'b0;
				rej_q    <= 1'b0;
				mzero_q  <= 1'b1;
				mbcast_q <= 1'b1;
			end else begin
				len_q    <= len_n;
				dots_q   <= dots_n;
				grp_q    <= grp_n;
				lead0_q  <= lead0_n;
				rej_q    <= rej_n;
				mzero_q  <= mzero_n;
				mbcast_q <= mbcast_n;
			end
		end
	end

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		en && final_req |=> (len_q == '0) && !rej_q && mzero_q && mbcast_q)
		else $error("scan state not cleared after final word");

	a_rej_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		en && !final_req && rej_q |=> rej_q)
		else $error("reject flag dropped inside a string");

	a_zero_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		mzero_q |-> (len_q <= ipv4tv_pkg::LEN_W'(ipv4tv_pkg::ZERO_LEN)))
		else $error("all-zero match beyond its pattern length");

	a_dots_need_len: assert property (@(posedge clk) disable iff (!arst_n)
		(dots_q != '0) |-> (len_q != '0))
		else $error("dot counted with no characters seen");

endmodule

// ===== rtl/ipv4_text_validator.sv =====
// Top level of the IPv4 text validator: input register, scan logic, result register.
// Takes one character word per cycle; the word with final_req set yields one result
// word, valid_res = 1 if the string is a dotted-quad IPv4 address that passes the
// checks (at most 15 characters, digits and exactly three dots, four groups of one
// to three digits, no leading zero in a multi-digit group, not 0.0.0.0 and not
// 255.255.255.255). A word passes the input register and the result register; the
// input register loads at the accepting edge, and the result register takes the verdict
// when the final word advances. A new word is accepted every cycle;
// the input side stalls only while a final word waits for a result register that is
// full and stalled.
`timescale 1ns / 1ps

module ipv4_text_validator #(
	parameter int MAX_LENGTH = ipv4tv_pkg::MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] symbol,
	input  logic       final_req,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       valid_res
);

	logic       valid_s1;
	logic [7:0] symbol_s1;
	logic       final_s1;
	logic       res_valid_q;
	logic       valid_res_q;
	logic       adv;
	logic       accept;
	logic       verdict;

	assign adv       = valid_s1 && (!final_s1 || !res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			symbol_s1 <= symbol;
			final_s1  <= final_req;
		end
	end

	ipv4tv_scan #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.symbol    (symbol_s1),
		.final_req (final_s1),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (adv && final_s1) || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && final_s1) begin
			valid_res_q <= verdict;
		end
	end

	assign res_valid = res_valid_q;
	assign valid_res = valid_res_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the IPv4 text validator: directed table, then random strings.
`timescale 1ns / 1ps

module testbench;

	localparam int FROM_SCAN = -1;
	localparam logic [7:0] PLAIN = 8'h23;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		string      text;
		logic [7:0] odd;
		int         verdict;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [7:0] symbol = '0;
	logic       final_req = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       valid_res;

	bit verdict_q [$];
	bit want;
	int errors = 0;
	int chars_sent = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	// scan state of the predictor
	logic [4:0] scan_len;
	logic [2:0] scan_dots;
	logic [1:0] scan_grp;
	bit         scan_grp_zero;
	bit         scan_bad;
	bit         scan_like_zero;
	bit         scan_like_bcast;

	// '#' in a row is replaced by the row's odd byte
	row_t dir_rows [24] = '{
		'{"1.2.3.4", PLAIN, 1},
		'{"0.0.0.0", PLAIN, 0},
		'{"255.255.255.255", PLAIN, 0},
		'{"255.255.255.254", PLAIN, 1},
		'{"7", PLAIN, 0},
		'{".", PLAIN, 0},
		'{".1.2.3", PLAIN, 0},
		'{"1..2.3", PLAIN, 0},
		'{"1.2.3.", PLAIN, 0},
		'{"1.2.3.4.", PLAIN, 0},
		'{"1234.1.1.1", PLAIN, 0},
		'{"01.2.3.4", PLAIN, 0},
		'{"100.0.10.9", PLAIN, FROM_SCAN},
		'{"999.999.999.99", PLAIN, FROM_SCAN},
		'{"1.2.3.4#", 8'h00, 0},
		'{"1.2#.3.4", 8'hFF, 0},
		'{"#.1.2.3", 8'h80, 0},
		'{"1/2.3.4", PLAIN, 0},
		'{"1.2.3:4", PLAIN, 0},
		'{"111.111.111.1111", PLAIN, 0},
		'{"1111111111111111111111111111111111111.2.3", PLAIN, 0},
		'{"0.0.0.00", PLAIN, FROM_SCAN},
		'{"0.0.0.1", PLAIN, FROM_SCAN},
		'{"1.2.3", PLAIN, 0}
	};

	ipv4_text_validator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.symbol    (symbol),
		.final_req (final_req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.valid_res (valid_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void scan_clear();
		scan_len = '0;
		scan_dots = '0;
		scan_grp = '0;
		scan_grp_zero = 1'b0;
		scan_bad = 1'b0;
		scan_like_zero = 1'b1;
		scan_like_bcast = 1'b1;
	endfunction

	// returns 1 when the character closes a string; ok then holds the verdict
	function automatic bit scan_char(input logic [7:0] c, input bit fin, output bit ok);
		string zero_pat;
		string bcast_pat;
		int pos;
		bit is_dig;
		bit is_dot;
		zero_pat = "0.0.0.0";
		bcast_pat = "255.255.255.255";
		ok = 1'b0;
		pos = scan_len;
		is_dig = (c >= ipv4tv_pkg::CHAR_ZERO) && (c <= ipv4tv_pkg::CHAR_NINE);
		is_dot = (c == ipv4tv_pkg::CHAR_DOT);
		if (pos >= zero_pat.len() || zero_pat[pos] != c)
			scan_like_zero = 1'b0;
		if (pos >= bcast_pat.len() || bcast_pat[pos] != c)
			scan_like_bcast = 1'b0;
		if (pos == 0 && !is_dig)
			scan_bad = 1'b1;
		if (scan_len != 5'd31)
			scan_len = scan_len + 5'd1;
		if (scan_len > ipv4tv_pkg::MAX_LENGTH)
			scan_bad = 1'b1;
		if (is_dot) begin
			if (scan_grp == 0)
				scan_bad = 1'b1;
			if (scan_dots != 3'd7)
				scan_dots = scan_dots + 3'd1;
			scan_grp = '0;
			scan_grp_zero = 1'b0;
		end else if (is_dig) begin
			if (scan_grp == 0) begin
				scan_grp_zero = (c == ipv4tv_pkg::CHAR_ZERO);
				scan_grp = 2'd1;
			end else begin
				if (scan_grp_zero)
					scan_bad = 1'b1;
				if (scan_grp == 2'd3)
					scan_bad = 1'b1;
				else
					scan_grp = scan_grp + 2'd1;
			end
		end else begin
			scan_bad = 1'b1;
		end
		if (!fin)
			return 1'b0;
		ok = !scan_bad && scan_dots == 3'd3 && scan_grp != 0;
		if (scan_like_zero && scan_len == 5'd7)
			ok = 1'b0;
		if (scan_like_bcast && scan_len == 5'd15)
			ok = 1'b0;
		scan_clear();
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_digit();
		if ($urandom_range(0, 3) == 0)
			return ipv4tv_pkg::CHAR_ZERO;
		return ipv4tv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic void make_text(output logic [7:0] t [$]);
		int kind;
		int n;
		int p;
		string s;
		t.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
			repeat (n) t.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 1) begin
			s = $urandom_range(0, 1) ? "255.255.255.255" : "0.0.0.0";
			for (int i = 0; i < s.len(); i++)
				t.push_back(s[i]);
			if ($urandom_range(0, 2) == 0)
				t[$urandom_range(0, t.size() - 1)] = rand_digit();
		end else begin
			for (int g = 0; g < 4; g++) begin
				if (g != 0)
					t.push_back(ipv4tv_pkg::CHAR_DOT);
				repeat ($urandom_range(1, 3)) t.push_back(rand_digit());
			end
			if (kind >= 7) begin
				p = $urandom_range(0, t.size() - 1);
				case ($urandom_range(0, 4))
					0: t[p] = 8'($urandom_range(0, 255));
					1: t.insert(p, ipv4tv_pkg::CHAR_DOT);
					2: t.delete(p);
					3: begin
						t.push_back(ipv4tv_pkg::CHAR_DOT);
						t.push_back(rand_digit());
					end
					default: repeat ($urandom_range(1, 20)) t.push_back(rand_digit());
				endcase
			end
		end
	endfunction

	// one word per character, final_req on the last one
	task automatic send_text(input logic [7:0] t [$], input int fixed);
		bit ok;
		for (int i = 0; i < t.size(); i++) begin
			symbol <= t[i];
			final_req <= (i == t.size() - 1);
			req_valid <= 1'b1;
			do @(posedge clk); while (req_stall);
			chars_sent++;
			if (scan_char(t[i], i == t.size() - 1, ok))
				verdict_q.push_back(fixed == FROM_SCAN ? ok : fixed[0]);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic [7:0] t [$];
		string s;
		scan_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[r]) begin
			t.delete();
			s = dir_rows[r].text;
			for (int i = 0; i < s.len(); i++)
				t.push_back(s[i] == PLAIN ? dir_rows[r].odd : s[i]);
			send_text(t, dir_rows[r].verdict);
		end
		req_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		@(posedge clk);
		hold_req = 1'b1;
		while (chars_sent < 700) begin
			make_text(t);
			send_text(t, FROM_SCAN);
		end
		idle_on = 1'b0;
		while (chars_sent < 830) begin
			make_text(t);
			send_text(t, FROM_SCAN);
		end
		req_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side stall: random bursts, plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (idle_on && arst_n && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected verdict word: valid_res %0b", valid_res);
			end else begin
				want = verdict_q.pop_front();
				if (valid_res !== want) begin
					errors++;
					if (errors <= 10)
						$display("verdict mismatch: expected %0b, got %0b", want, valid_res);
				end
			end
		end
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ipv4tv_pkg.sv
rtl/ipv4tv_scan.sv
rtl/ipv4_text_validator.sv
verif/testbench.sv
